/* src/sdinit_pkg.sv */
package sdinit_pkg;

  // card phase
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhReady = 2'd1;
  localparam logic [1:0] PhIdent = 2'd2;
  localparam logic [1:0] PhStby  = 2'd3;

  // idle phase steps
  localparam logic [2:0] IsCmd0   = 3'd0;
  localparam logic [2:0] IsCmd8   = 3'd1;
  localparam logic [2:0] IsCmd55  = 3'd2;
  localparam logic [2:0] IsAcmd41 = 3'd3;
  localparam logic [2:0] IsCheck  = 3'd4;

  // ready phase steps
  localparam logic [1:0] RsCmd11 = 2'd0;
  localparam logic [1:0] RsCmd2  = 2'd1;
  localparam logic [1:0] RsCid   = 2'd2;

  // identification phase steps
  localparam logic DsCmd3 = 1'b0;
  localparam logic DsRca  = 1'b1;

  // response kinds
  localparam logic [2:0] RkR1 = 3'd0;
  localparam logic [2:0] RkR2 = 3'd1;
  localparam logic [2:0] RkR3 = 3'd2;
  localparam logic [2:0] RkR6 = 3'd3;
  localparam logic [2:0] RkR7 = 3'd4;

  // card kinds
  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindV1      = 2'd1;
  localparam logic [1:0] KindV2Sc    = 2'd2;
  localparam logic [1:0] KindV2Hc    = 2'd3;

  // command numbers
  localparam logic [5:0] Cmd0  = 6'd0;
  localparam logic [5:0] Cmd2  = 6'd2;
  localparam logic [5:0] Cmd3  = 6'd3;
  localparam logic [5:0] Cmd8  = 6'd8;
  localparam logic [5:0] Cmd11 = 6'd11;
  localparam logic [5:0] Cmd41 = 6'd41;
  localparam logic [5:0] Cmd55 = 6'd55;

  // engine error codes
  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrNoResp = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CfgPcie1v2  = 2'd0;
  localparam logic [1:0] CfgPcieAvl  = 2'd1;
  localparam logic [1:0] CfgSupply   = 2'd2;
  localparam logic [1:0] CfgCheckPat = 2'd3;

  localparam logic [23:0] VoltWindowReset = 24'hFF8000;

  typedef struct packed {
    logic        pcie_1v2;
    logic        pcie_avl;
    logic [3:0]  supply;
    logic [7:0]  check_pat;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  idle_step;
    logic [1:0]  ready_step;
    logic        ident_step;
    logic        req_pend;
    logic        awaiting;
    logic [5:0]  pend_idx;
    logic [31:0] pend_arg;
    logic [2:0]  pend_kind;
    logic        last_ready;   // bit 31 of the last response
    logic [1:0]  kind;
    logic        high_cap;
    logic        low_volt;
    logic [23:0] volt_win;
    logic [15:0] rca;
    logic        slow_clk;
    logic        clr_pulse;
  } state_t;

  localparam state_t StateReset = '{
    phase:      PhIdle,
    idle_step:  IsCmd0,
    ready_step: RsCmd11,
    ident_step: DsCmd3,
    req_pend:   1'b0,
    awaiting:   1'b0,
    pend_idx:   6'd0,
    pend_arg:   32'd0,
    pend_kind:  RkR1,
    last_ready: 1'b0,
    kind:       KindUnknown,
    high_cap:   1'b1,
    low_volt:   1'b0,
    volt_win:   VoltWindowReset,
    rca:        16'd0,
    slow_clk:   1'b1,
    clr_pulse:  1'b0
  };

endpackage

/* src/sdinit_next.sv */
module sdinit_next (
  input  sdinit_pkg::state_t cur_i,
  input  sdinit_pkg::cfg_t   cfg_i,
  input  logic               req_accepted_i,
  input  logic               resp_valid_i,
  input  logic [31:0]        resp_argument_i,
  input  logic [1:0]         engine_error_i,
  output sdinit_pkg::state_t nxt_o
);

  always_comb begin
    nxt_o = cur_i;
    nxt_o.clr_pulse = 1'b0;

    if (cur_i.req_pend) begin
      if (req_accepted_i) begin
        nxt_o.req_pend = 1'b0;
        nxt_o.awaiting = 1'b1;
      end
    end else if (resp_valid_i && cur_i.awaiting) begin
      nxt_o.awaiting   = 1'b0;
      nxt_o.last_ready = resp_argument_i[31];
      if (cur_i.pend_kind == sdinit_pkg::RkR3) begin
        // OCR only counts once the card reports power-up done
        if (resp_argument_i[31]) begin
          nxt_o.volt_win = resp_argument_i[23:0];
          nxt_o.high_cap = resp_argument_i[30];
          if (resp_argument_i[30]) begin
            nxt_o.kind = sdinit_pkg::KindV2Hc;
          end else if (cur_i.kind == sdinit_pkg::KindUnknown) begin
            nxt_o.kind = sdinit_pkg::KindV2Sc;
          end
          nxt_o.low_volt = resp_argument_i[24];
        end
      end else if (cur_i.pend_kind == sdinit_pkg::RkR6) begin
        nxt_o.rca = resp_argument_i[31:16];
      end
    end else if (cur_i.awaiting) begin
      // waiting for the response
    end else begin
      unique case (cur_i.phase)
        sdinit_pkg::PhIdle: begin
          nxt_o.slow_clk = 1'b1;
          unique case (cur_i.idle_step)
            sdinit_pkg::IsCmd0: begin
              nxt_o.kind      = sdinit_pkg::KindUnknown;
              nxt_o.high_cap  = 1'b1;
              nxt_o.low_volt  = 1'b0;
              nxt_o.rca       = '0;
              nxt_o.req_pend  = 1'b1;
              nxt_o.pend_idx  = sdinit_pkg::Cmd0;
              nxt_o.pend_kind = sdinit_pkg::RkR1;
              nxt_o.pend_arg  = '0;
              nxt_o.idle_step = sdinit_pkg::IsCmd8;
            end
            sdinit_pkg::IsCmd8: begin
              nxt_o.pend_idx  = sdinit_pkg::Cmd8;
              nxt_o.pend_kind = sdinit_pkg::RkR7;
              nxt_o.pend_arg  = {18'd0, cfg_i.pcie_1v2, cfg_i.pcie_avl,
                                 cfg_i.supply, cfg_i.check_pat};
              if (engine_error_i == sdinit_pkg::ErrNone) begin
                nxt_o.req_pend  = 1'b1;
                nxt_o.idle_step = sdinit_pkg::IsCmd55;
              end else begin
                nxt_o.clr_pulse = 1'b1;
                nxt_o.idle_step = sdinit_pkg::IsCmd0;
              end
            end
            sdinit_pkg::IsCmd55: begin
              // no answer to CMD8: version 1.x card
              if (engine_error_i == sdinit_pkg::ErrNoResp) begin
                nxt_o.kind      = sdinit_pkg::KindV1;
                nxt_o.high_cap  = 1'b0;
                nxt_o.clr_pulse = 1'b1;
              end
              nxt_o.req_pend  = 1'b1;
              nxt_o.pend_idx  = sdinit_pkg::Cmd55;
              nxt_o.pend_kind = sdinit_pkg::RkR1;
              nxt_o.pend_arg  = '0;
              nxt_o.idle_step = sdinit_pkg::IsAcmd41;
            end
            sdinit_pkg::IsAcmd41: begin
              nxt_o.req_pend  = 1'b1;
              nxt_o.pend_idx  = sdinit_pkg::Cmd41;
              nxt_o.pend_kind = sdinit_pkg::RkR3;
              nxt_o.pend_arg  = {1'b0, cur_i.high_cap, 5'd0, cur_i.low_volt,
                                 cur_i.volt_win};
              nxt_o.idle_step = sdinit_pkg::IsCheck;
            end
            sdinit_pkg::IsCheck: begin
              if (!cur_i.last_ready) begin
                nxt_o.idle_step = sdinit_pkg::IsCmd55;
              end else begin
                nxt_o.ready_step = cur_i.low_volt ? sdinit_pkg::RsCmd11
                                                  : sdinit_pkg::RsCmd2;
                nxt_o.phase = sdinit_pkg::PhReady;
              end
            end
            default: begin
              nxt_o.idle_step = sdinit_pkg::IsCmd0;
            end
          endcase
        end
        sdinit_pkg::PhReady: begin
          unique case (cur_i.ready_step)
            sdinit_pkg::RsCmd11: begin
              nxt_o.req_pend   = 1'b1;
              nxt_o.pend_idx   = sdinit_pkg::Cmd11;
              nxt_o.pend_kind  = sdinit_pkg::RkR1;
              nxt_o.pend_arg   = '0;
              nxt_o.ready_step = sdinit_pkg::RsCmd2;
            end
            sdinit_pkg::RsCmd2: begin
              nxt_o.req_pend   = 1'b1;
              nxt_o.pend_idx   = sdinit_pkg::Cmd2;
              nxt_o.pend_kind  = sdinit_pkg::RkR2;
              nxt_o.pend_arg   = '0;
              nxt_o.ready_step = sdinit_pkg::RsCid;
            end
            sdinit_pkg::RsCid: begin
              nxt_o.phase      = sdinit_pkg::PhIdent;
              nxt_o.ident_step = sdinit_pkg::DsCmd3;
            end
            default: begin
              // unused step code holds
            end
          endcase
        end
        sdinit_pkg::PhIdent: begin
          if (cur_i.ident_step == sdinit_pkg::DsCmd3) begin
            nxt_o.req_pend   = 1'b1;
            nxt_o.pend_idx   = sdinit_pkg::Cmd3;
            nxt_o.pend_kind  = sdinit_pkg::RkR6;
            nxt_o.pend_arg   = '0;
            nxt_o.ident_step = sdinit_pkg::DsRca;
          end else begin
            nxt_o.phase    = sdinit_pkg::PhStby;
            nxt_o.slow_clk = 1'b0;
          end
        end
        default: begin
          // standby: nothing left to do
        end
      endcase
    end
  end

endmodule

/* src/sd_card_init_sequencer_top.sv */
// SD-mode card bring-up sequencer. Each input item is one snapshot of the
// command engine (accept, response with argument, error code); each item gives
// exactly one result item holding the command request and card status as they
// stand after that item. One item per clock cycle: the next-state logic is a
// single combinational pass into the sequencer registers, which also serve as
// the result register, so an item is accepted whenever the result slot is empty
// or is being taken in the same cycle. Configuration writes are always ready and
// take effect from the next item.
module sd_card_init_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_accepted_i,
  input  logic        resp_valid_i,
  input  logic [31:0] resp_argument_i,
  input  logic [1:0]  engine_error_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        cmd_valid_o,
  output logic [5:0]  cmd_index_o,
  output logic [31:0] cmd_argument_o,
  output logic [2:0]  expected_resp_o,
  output logic        error_clear_o,
  output logic        slow_clock_enable_o,
  output logic [1:0]  card_kind_o,
  output logic [1:0]  card_phase_o,
  output logic [15:0] relative_address_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  sdinit_pkg::cfg_t   cfg_q;
  sdinit_pkg::state_t st_q, st_d;
  logic               out_valid_q;
  logic               in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pcie_1v2  <= 1'b0;
      cfg_q.pcie_avl  <= 1'b0;
      cfg_q.supply    <= 4'd1;
      cfg_q.check_pat <= 8'h55;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdinit_pkg::CfgPcie1v2:  cfg_q.pcie_1v2  <= cfg_data_i[0];
        sdinit_pkg::CfgPcieAvl:  cfg_q.pcie_avl  <= cfg_data_i[0];
        sdinit_pkg::CfgSupply:   cfg_q.supply    <= cfg_data_i[3:0];
        sdinit_pkg::CfgCheckPat: cfg_q.check_pat <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sdinit_next u_next (
    .cur_i           (st_q),
    .cfg_i           (cfg_q),
    .req_accepted_i  (req_accepted_i),
    .resp_valid_i    (resp_valid_i),
    .resp_argument_i (resp_argument_i),
    .engine_error_i  (engine_error_i),
    .nxt_o           (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sdinit_pkg::StateReset;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign cmd_valid_o         = st_q.req_pend;
  assign cmd_index_o         = st_q.pend_idx;
  assign cmd_argument_o      = st_q.pend_arg;
  assign expected_resp_o     = st_q.pend_kind;
  assign error_clear_o       = st_q.clr_pulse;
  assign slow_clock_enable_o = st_q.slow_clk;
  assign card_kind_o         = st_q.kind;
  assign card_phase_o        = st_q.phase;
  assign relative_address_o  = st_q.rca;

endmodule
